[src/fpq_pkg.sv]
// ----------------------------------------------------------------------------
// fpq_pkg
// Types, codes and defaults shared by the five-level priority fifo modules.
// ----------------------------------------------------------------------------
package fpq_pkg;

    localparam int DEPTH_DEF  = 16;
    localparam int LEVELS_DEF = 5;
    localparam int CFG_W      = 5;
    localparam int VAL_W      = 32;
    localparam int PRI_W      = 3;

    typedef enum logic [1:0] {
        CMD_ENQ        = 2'd0,
        CMD_DEQ_FRONT  = 2'd1,
        CMD_DEQ_HIGH   = 2'd2,
        CMD_PEEK       = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_BADPRIO = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHK,
        S_SHIFT,
        S_RESP
    } t_state;

    typedef struct packed {
        t_cmd                     command;
        logic signed [VAL_W-1:0]  item_value;
        logic        [PRI_W-1:0]  item_priority;
    } t_in_word;

    typedef struct packed {
        logic signed [VAL_W-1:0]  out_value;
        logic        [PRI_W-1:0]  out_priority;
        t_status                  status;
    } t_out_word;

    typedef struct packed {
        logic             inc;
        logic [PRI_W-1:0] inc_lvl;
        logic             dec;
        logic [PRI_W-1:0] dec_lvl;
    } t_lvl_ctl;

endpackage

[src/fpq_ram.sv]
// ----------------------------------------------------------------------------
// fpq_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module fpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/fpq_levels.sv]
// ----------------------------------------------------------------------------
// fpq_levels
// Per-level entry counters and the highest occupied level.
// ----------------------------------------------------------------------------
module fpq_levels
    import fpq_pkg::*;
#(
    parameter int DEPTH  = DEPTH_DEF,
    parameter int LEVELS = LEVELS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_lvl_ctl         i_ctl,
    output logic [PRI_W-1:0] o_high_lvl
);

    localparam int CW  = $clog2(DEPTH + 1);
    localparam int LVW = (LEVELS > 1) ? $clog2(LEVELS) : 1;

    logic [CW-1:0] r_cnt [LEVELS];
    logic [CW-1:0] n_cnt [LEVELS];

    always_comb begin
        for (int l = 0; l < LEVELS; l++) begin
            n_cnt[l] = r_cnt[l];
        end
        if (i_ctl.inc) begin
            n_cnt[i_ctl.inc_lvl[LVW-1:0]] = r_cnt[i_ctl.inc_lvl[LVW-1:0]] + CW'(1);
        end
        if (i_ctl.dec) begin
            n_cnt[i_ctl.dec_lvl[LVW-1:0]] = r_cnt[i_ctl.dec_lvl[LVW-1:0]] - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < LEVELS; l++) begin
                r_cnt[l] <= '0;
            end
        end else begin
            for (int l = 0; l < LEVELS; l++) begin
                r_cnt[l] <= n_cnt[l];
            end
        end
    end

    always_comb begin
        o_high_lvl = '0;
        for (int l = 0; l < LEVELS; l++) begin
            if (r_cnt[l] != '0) begin
                o_high_lvl = PRI_W'(l);
            end
        end
    end

endmodule

[src/fpq_ctrl.sv]
// ----------------------------------------------------------------------------
// fpq_ctrl
// Command sequencer: enqueue, one-entry-per-cycle scan and shift-down removal.
// ----------------------------------------------------------------------------
module fpq_ctrl
    import fpq_pkg::*;
#(
    parameter int DEPTH  = DEPTH_DEF,
    parameter int LEVELS = LEVELS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_W-1:0]         i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  t_in_word                 i_in_data,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output t_out_word                o_out_data,
    output logic                     o_ram_we,
    output logic [$clog2(DEPTH)-1:0] o_ram_waddr,
    output logic [PRI_W+VAL_W-1:0]   o_ram_wdata,
    output logic [$clog2(DEPTH)-1:0] o_ram_raddr,
    input  logic [PRI_W+VAL_W-1:0]   i_ram_rdata,
    output t_lvl_ctl                 o_lvl_ctl,
    input  logic [PRI_W-1:0]         i_high_lvl
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (CW > CFG_W) ? CW : CFG_W;

    t_state           r_state, n_state;
    logic [CW-1:0]    r_occ, n_occ;
    logic [AW-1:0]    r_idx, n_idx;
    logic [CFG_W-1:0] r_limit;
    logic             r_front, n_front;
    logic             r_peek, n_peek;
    logic [PRI_W-1:0] r_lvl, n_lvl;
    t_out_word        r_res, n_res;

    logic [LW-1:0]    lim_ext;
    logic             full;
    logic             bad_prio;
    logic             accept;
    logic [PRI_W-1:0] rd_prio;
    logic [VAL_W-1:0] rd_val;
    logic             match;
    logic             more_chk;
    logic             more_sh;

    assign lim_ext  = (r_limit == '0 || LW'(r_limit) > LW'(DEPTH)) ? LW'(DEPTH) : LW'(r_limit);
    assign full     = LW'(r_occ) >= lim_ext;
    assign bad_prio = {1'b0, i_in_data.item_priority} >= (PRI_W + 1)'(LEVELS);
    assign accept   = i_in_valid && o_in_ready;
    assign rd_prio  = i_ram_rdata[PRI_W+VAL_W-1:VAL_W];
    assign rd_val   = i_ram_rdata[VAL_W-1:0];
    assign match    = r_front || (rd_prio == r_lvl);
    assign more_chk = (CW'(r_idx) + CW'(1)) < r_occ;
    assign more_sh  = (CW'(r_idx) + CW'(1)) < r_occ;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_RESP);
    assign o_out_data  = r_res;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_in_data.command == CMD_ENQ || r_occ == '0) begin
                        n_state = S_RESP;
                    end else begin
                        n_state = S_CHK;
                    end
                end
            end
            S_CHK: begin
                if (match) begin
                    if (r_peek || !more_chk) begin
                        n_state = S_RESP;
                    end else begin
                        n_state = S_SHIFT;
                    end
                end
            end
            S_SHIFT: begin
                if (!more_sh) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_occ       = r_occ;
        n_idx       = r_idx;
        n_front     = r_front;
        n_peek      = r_peek;
        n_lvl       = r_lvl;
        n_res       = r_res;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_idx;
        o_ram_wdata = i_ram_rdata;
        o_ram_raddr = '0;
        o_lvl_ctl   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_res = '{out_value: '0, out_priority: '0, status: ST_OK};
                    n_idx = '0;
                    n_front = (i_in_data.command == CMD_DEQ_FRONT);
                    n_peek  = (i_in_data.command == CMD_PEEK);
                    n_lvl   = i_high_lvl;
                    if (i_in_data.command == CMD_ENQ) begin
                        if (full) begin
                            n_res.status = ST_FULL;
                        end else if (bad_prio) begin
                            n_res.status = ST_BADPRIO;
                        end else begin
                            o_ram_we          = 1'b1;
                            o_ram_waddr       = r_occ[AW-1:0];
                            o_ram_wdata       = {i_in_data.item_priority, i_in_data.item_value};
                            n_occ             = r_occ + CW'(1);
                            o_lvl_ctl.inc     = 1'b1;
                            o_lvl_ctl.inc_lvl = i_in_data.item_priority;
                        end
                    end else if (r_occ == '0) begin
                        n_res.status = ST_EMPTY;
                    end
                end
            end
            S_CHK: begin
                if (match) begin
                    n_res.out_value    = rd_val;
                    n_res.out_priority = rd_prio;
                    if (!r_peek) begin
                        n_occ             = r_occ - CW'(1);
                        o_lvl_ctl.dec     = 1'b1;
                        o_lvl_ctl.dec_lvl = rd_prio;
                        o_ram_raddr       = AW'(CW'(r_idx) + CW'(1));
                    end
                end else begin
                    n_idx       = r_idx + AW'(1);
                    o_ram_raddr = AW'(CW'(r_idx) + CW'(1));
                end
            end
            S_SHIFT: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = r_idx;
                o_ram_wdata = i_ram_rdata;
                if (more_sh) begin
                    n_idx       = r_idx + AW'(1);
                    o_ram_raddr = AW'(CW'(r_idx) + CW'(2));
                end
            end
            S_RESP: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_occ   <= '0;
            r_limit <= '0;
            r_idx   <= '0;
            r_front <= 1'b0;
            r_peek  <= 1'b0;
            r_lvl   <= '0;
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
            r_idx   <= n_idx;
            r_front <= n_front;
            r_peek  <= n_peek;
            r_lvl   <= n_lvl;
            if (i_cfg_valid && o_cfg_ready) begin
                r_limit <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= CW'(DEPTH))
        else $error("occupancy above depth");

    a_scan_in_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHK) |-> (CW'(r_idx) < r_occ))
        else $error("scan ran past stored entries");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_res.status == ST_EMPTY) |->
            (r_res.out_value == '0 && r_res.out_priority == '0))
        else $error("empty result carries data");

    a_shift_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHK && match && !r_peek) |=> (r_occ == $past(r_occ) - CW'(1)))
        else $error("removal did not shrink occupancy");

endmodule

[src/five_level_priority_fifo_top.sv]
// ----------------------------------------------------------------------------
// five_level_priority_fifo_top
// Bounded arrival-order queue of tagged values with oldest and
// highest-priority removal, peek and a capacity limit register.
//
//   channel  direction  signals                              word
//   cfg      in         i_cfg_valid / o_cfg_ready            i_cfg_data (limit)
//   in       in         i_in_valid  / o_in_ready             i_in_data
//   out      out        o_out_valid / i_out_ready            o_out_data
//
// enqueue, full, invalid or empty: result valid in the cycle after accept
// dequeue/peek: scan from the front up to the matching entry, then shift the later
//   entries down (none for peek), one entry per cycle through the single ram port
// one word in flight; o_in_ready is low until the result is taken
// synchronous active-low reset clears occupancy, level counts and limit
// ----------------------------------------------------------------------------
module five_level_priority_fifo_top
    import fpq_pkg::*;
#(
    parameter int DEPTH  = DEPTH_DEF,
    parameter int LEVELS = LEVELS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_word         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_word        o_out_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int RW = PRI_W + VAL_W;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [RW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [RW-1:0] ram_rdata;
    t_lvl_ctl      lvl_ctl;
    logic [PRI_W-1:0] high_lvl;

    fpq_ram #(
        .WIDTH (RW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    fpq_levels #(
        .DEPTH  (DEPTH),
        .LEVELS (LEVELS)
    ) u_levels (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (lvl_ctl),
        .o_high_lvl (high_lvl)
    );

    fpq_ctrl #(
        .DEPTH  (DEPTH),
        .LEVELS (LEVELS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata),
        .o_lvl_ctl   (lvl_ctl),
        .i_high_lvl  (high_lvl)
    );

endmodule

[tb/five_level_priority_fifo_top_tb.sv]
// ----------------------------------------------------------------------------
// five_level_priority_fifo_top_tb
// Drives command words into the priority fifo and checks every result word
// against a behavioral model of the queue: arrival order, oldest-first and
// highest-level removal, peek, full, empty and bad-priority status, and the
// capacity limit at several settings, under random idling on both channels.
// ----------------------------------------------------------------------------
module five_level_priority_fifo_top_tb;
    import fpq_pkg::*;

    typedef struct {
        logic signed [VAL_W-1:0] v;
        logic [PRI_W-1:0]        p;
    } t_entry;

    class fifo_scoreboard;
        logic [CFG_W-1:0] limit;
        t_entry           held[$];
        t_out_word        expected[$];
        int               errors;
        int               words;
        int               status_seen[4];

        function new();
            limit  = '0;
            errors = 0;
            words  = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function void set_limit(logic [CFG_W-1:0] v);
            limit = v;
        endfunction

        function int room();
            if (limit == 0 || limit > DEPTH_DEF) return DEPTH_DEF;
            return int'(limit);
        endfunction

        // oldest entry of the highest level present
        function int top_pos();
            for (int lvl = LEVELS_DEF - 1; lvl >= 0; lvl--) begin
                foreach (held[i]) begin
                    if (held[i].p == lvl) return i;
                end
            end
            return 0;
        endfunction

        function void note_word(t_in_word w);
            t_out_word r;
            t_entry    e;
            int        pos;
            r = '0;
            r.status = ST_OK;
            words++;
            if (w.command == CMD_ENQ) begin
                if (held.size() >= room()) begin
                    r.status = ST_FULL;
                end else if (w.item_priority >= LEVELS_DEF) begin
                    r.status = ST_BADPRIO;
                end else begin
                    e.v = w.item_value;
                    e.p = w.item_priority;
                    held.push_back(e);
                end
            end else if (held.size() == 0) begin
                r.status = ST_EMPTY;
            end else begin
                pos = (w.command == CMD_DEQ_FRONT) ? 0 : top_pos();
                r.out_value    = held[pos].v;
                r.out_priority = held[pos].p;
                if (w.command != CMD_PEEK) held.delete(pos);
            end
            expected.push_back(r);
        endfunction

        function void check_word(t_out_word got);
            t_out_word want;
            if (expected.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result word: value %0d prio %0d status %0d",
                             got.out_value, got.out_priority, got.status);
                return;
            end
            want = expected.pop_front();
            status_seen[want.status]++;
            if (got.out_value !== want.out_value || got.out_priority !== want.out_priority
                    || got.status !== want.status) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch v/p/s: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                             want.out_value, want.out_priority, want.status,
                             got.out_value, got.out_priority, got.status);
            end
        endfunction
    endclass

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [CFG_W-1:0] i_cfg_data  = '0;
    logic             i_in_valid  = 1'b0;
    logic             o_in_ready;
    t_in_word         i_in_data   = '0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    t_out_word        o_out_data;

    fifo_scoreboard sb;
    int send_pct    = 0;
    int recv_pct    = 0;
    int hold_cycles = 0;
    int limit_writes = 0;

    five_level_priority_fifo_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    // receiver: long hold-off when requested, random stalls otherwise
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_out_ready = 1'b0;
            hold_cycles--;
        end else begin
            i_out_ready = (recv_pct == 0) || ($urandom_range(99) >= recv_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && sb != null) begin
            if (i_cfg_valid && o_cfg_ready) sb.set_limit(i_cfg_data);
            if (i_in_valid && o_in_ready) sb.note_word(i_in_data);
            if (o_out_valid && i_out_ready) sb.check_word(o_out_data);
        end
    end

    task automatic send_word(t_in_word w);
        int gap;
        gap = 0;
        if (send_pct > 0)
            while (gap < 40 && $urandom_range(99) < send_pct) gap++;
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
        end
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_in_data  = w;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic send_cmd(t_cmd c, logic signed [VAL_W-1:0] v, logic [PRI_W-1:0] p);
        t_in_word w;
        w.command       = c;
        w.item_value    = v;
        w.item_priority = p;
        send_word(w);
    endtask

    task automatic release_in();
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic wait_drain();
        while (sb.expected.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [CFG_W-1:0] v);
        release_in();
        wait_drain();
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = v;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        limit_writes++;
    endtask

    function automatic t_in_word rand_word(int enq_pct);
        t_in_word w;
        int       r;
        if ($urandom_range(99) < enq_pct) w.command = CMD_ENQ;
        else w.command = t_cmd'($urandom_range(3, 1));
        r = $urandom_range(15);
        case (r)
            0: w.item_value = 32'sh8000_0000;
            1: w.item_value = 32'sh7fff_ffff;
            2: w.item_value = -32'sd1;
            3: w.item_value = '0;
            default: w.item_value = $urandom;
        endcase
        if ($urandom_range(9) == 0) w.item_priority = PRI_W'($urandom_range(7, 5));
        else w.item_priority = PRI_W'($urandom_range(4, 0));
        return w;
    endfunction

    initial begin
        logic [CFG_W-1:0] lims[10];
        int               enq_pct;
        sb = new();
        lims = '{5'd0, 5'd16, 5'd1, 5'd31, 5'd17, 5'd4, 5'd2, 5'd9, 5'd0, 5'd13};
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty, bad priority, extremes, level order, full, lowered limit
        write_limit(5'd0);
        send_cmd(CMD_DEQ_FRONT, 32'sd0, 3'd0);
        send_cmd(CMD_DEQ_HIGH, 32'sd0, 3'd0);
        send_cmd(CMD_PEEK, 32'sd0, 3'd0);
        send_cmd(CMD_ENQ, 32'sd5, 3'd5);
        send_cmd(CMD_ENQ, 32'sd7, 3'd7);
        send_cmd(CMD_ENQ, 32'sh8000_0000, 3'd0);
        send_cmd(CMD_ENQ, 32'sh7fff_ffff, 3'd4);
        send_cmd(CMD_ENQ, -32'sd1, 3'd2);
        send_cmd(CMD_ENQ, 32'sd0, 3'd4);
        send_cmd(CMD_ENQ, 32'sd1, 3'd1);
        send_cmd(CMD_PEEK, 32'sd0, 3'd0);
        send_cmd(CMD_DEQ_HIGH, 32'sd0, 3'd0);
        send_cmd(CMD_PEEK, 32'sd0, 3'd0);
        send_cmd(CMD_DEQ_HIGH, 32'sd0, 3'd0);
        send_cmd(CMD_DEQ_HIGH, 32'sd0, 3'd0);
        send_cmd(CMD_DEQ_FRONT, 32'sd0, 3'd0);
        write_limit(5'd2);
        send_cmd(CMD_ENQ, 32'sd11, 3'd3);
        send_cmd(CMD_ENQ, 32'sd12, 3'd3);
        send_cmd(CMD_ENQ, 32'sd13, 3'd7);
        write_limit(5'd1);
        send_cmd(CMD_ENQ, 32'sd14, 3'd2);
        send_cmd(CMD_DEQ_FRONT, 32'sd0, 3'd0);
        send_cmd(CMD_DEQ_HIGH, 32'sd0, 3'd0);
        send_cmd(CMD_DEQ_HIGH, 32'sd0, 3'd0);

        // random phases: fill and drain bursts under each idling mode
        for (int ph = 0; ph < 10; ph++) begin
            write_limit(lims[ph]);
            case (ph % 4)
                0: begin send_pct = 0;  recv_pct = 0;  end
                1: begin send_pct = 62; recv_pct = 0;  end
                2: begin send_pct = 0;  recv_pct = 62; end
                default: begin send_pct = 12; recv_pct = 12; end
            endcase
            if (ph == 4) hold_cycles = 400;
            for (int i = 0; i < 125; i++) begin
                if (ph == 6 && i == 60) begin
                    release_in();
                    wait_drain();
                end
                enq_pct = ((i / 20) % 2 == 0) ? 70 : 30;
                send_word(rand_word(enq_pct));
            end
        end

        release_in();
        wait_drain();
        repeat (60) @(posedge i_clk);
        $display("covered %0d words over %0d limit writes, mismatches %0d",
                 sb.words, limit_writes, sb.errors);
        $display("results seen: ok %0d, full %0d, empty %0d, bad priority %0d",
                 sb.status_seen[ST_OK], sb.status_seen[ST_FULL],
                 sb.status_seen[ST_EMPTY], sb.status_seen[ST_BADPRIO]);
        if (sb.errors == 0 && sb.expected.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #6000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

[five_level_priority_fifo_top.f]
src/fpq_pkg.sv
src/fpq_ram.sv
src/fpq_levels.sv
src/fpq_ctrl.sv
src/five_level_priority_fifo_top.sv
tb/five_level_priority_fifo_top_tb.sv
